>>> rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   // Field widths of the request and response items
   localparam int REQ_W   = 17;
   localparam int OFS_W   = 16;
   localparam int BYTES_W = 17;
   // Rounded request plus header: (131071 + 7) & ~3 fits in 18 bits
   localparam int NEED_W  = 18;

   localparam int HEAP_BYTES_DEFAULT = 65536;

   // Header flag codes (low two bits of a header word)
   localparam logic [1:0] FLAG_FREE = 2'd0;
   localparam logic [1:0] FLAG_USED = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_WR_HDR,
      ST_WR_REM,
      ST_GRANT,
      ST_FAIL
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_req;    // capture request, compute rounded size
      logic clear_pos;   // point the walk at offset 0
      logic advance;     // step to the next header
      logic latch_have;  // keep the size of the chunk that fits
      logic write_hdr;   // mark the chunk as used
      logic write_rem;   // write the free remainder header
      logic load_rsp;    // load the response register
      logic grant;       // response carries a grant
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_bad;    // zero request or larger than the heap
      logic hdr_zero;    // current header has size zero
      logic hdr_fit;     // current chunk is free and large enough
      logic at_end;      // next header lies at or past the heap end
      logic rem_ok;      // a remainder header is to be written
   } status_type;

endpackage

>>> rtl/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for allocation requests and allocation responses.
// ----------------------------------------------------------------------------
interface ffha_req_if;
   logic                         valid;
   logic                         ready;
   logic [ffha_pkg::REQ_W-1:0]   request_bytes;

   modport source (output valid, output request_bytes, input ready);
   modport sink   (input valid, input request_bytes, output ready);
endinterface

interface ffha_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         grant_ok;
   logic [ffha_pkg::OFS_W-1:0]   header_offset;
   logic [ffha_pkg::BYTES_W-1:0] chunk_bytes;

   modport source (output valid, output grant_ok, output header_offset,
                   output chunk_bytes, input ready);
   modport sink   (input valid, input grant_ok, input header_offset,
                   input chunk_bytes, output ready);
endinterface

>>> rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for the header walk: check, walk, mark, split, respond.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ffha_pkg::status_type status,
   output ffha_pkg::cmd_type    cmd
);

   ffha_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ffha_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.clear_pos = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ffha_pkg::ST_CHECK;
            end
         end
         ffha_pkg::ST_CHECK: begin
            state_in = status.need_bad ? ffha_pkg::ST_FAIL : ffha_pkg::ST_WALK;
         end
         ffha_pkg::ST_WALK: begin
            if (status.hdr_zero) begin
               state_in = ffha_pkg::ST_FAIL;
            end else if (status.hdr_fit) begin
               cmd.latch_have = 1'b1;
               state_in       = ffha_pkg::ST_WR_HDR;
            end else if (status.at_end) begin
               state_in = ffha_pkg::ST_FAIL;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ffha_pkg::ST_WR_HDR: begin
            cmd.write_hdr = 1'b1;
            state_in = status.rem_ok ? ffha_pkg::ST_WR_REM : ffha_pkg::ST_GRANT;
         end
         ffha_pkg::ST_WR_REM: begin
            cmd.write_rem = 1'b1;
            state_in      = ffha_pkg::ST_GRANT;
         end
         ffha_pkg::ST_GRANT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               cmd.grant    = 1'b1;
               state_in     = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_FAIL: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ffha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule

>>> rtl/ffha_datapath.sv
// ----------------------------------------------------------------------------
// ffha_datapath
// Header memory, walk pointer, size arithmetic and response register.
// ----------------------------------------------------------------------------
module ffha_datapath #(
   parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ffha_pkg::cmd_type              cmd,
   output ffha_pkg::status_type           status,
   input  logic [ffha_pkg::REQ_W-1:0]     request_bytes,
   output logic                           grant_ok,
   output logic [ffha_pkg::OFS_W-1:0]     header_offset,
   output logic [ffha_pkg::BYTES_W-1:0]   chunk_bytes
);

   localparam int HEAP_WORDS = HEAP_BYTES / 4;
   localparam int ADDR_W     = $clog2(HEAP_WORDS);
   localparam int HDR_W      = $clog2(HEAP_BYTES + 1);
   localparam int POS_W      = HDR_W + 1;
   localparam int CMP_W      = (POS_W > ffha_pkg::NEED_W) ? POS_W : ffha_pkg::NEED_W;
   localparam int SUM_W      = CMP_W + 1;

   logic [HDR_W-1:0]            mem [0:HEAP_WORDS-1];

   logic [ffha_pkg::NEED_W-1:0] need_ff;
   logic                        req_zero_ff;
   logic [HDR_W-1:0]            pos_ff, pos_in;
   logic [HDR_W-1:0]            have_ff;
   logic [HDR_W-1:0]            rdata_ff;
   logic                        init_ff;   // word 0 still holds its reset value
   logic                        hit_ff;    // last read hit word 0 before its first write

   logic [ffha_pkg::NEED_W-1:0] need_sum;
   logic [HDR_W-1:0]            hdr;
   logic [HDR_W-1:0]            csize;
   logic [POS_W-1:0]            next_pos;
   logic [SUM_W-1:0]            rem_pos;
   logic [CMP_W-1:0]            rem_size;
   logic [ADDR_W-1:0]           rd_word;
   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_word;
   logic [HDR_W-1:0]            wr_data;

   // round up to a word and add the header: ((r + 3) & ~3) + 4
   assign need_sum = ffha_pkg::NEED_W'(request_bytes) + ffha_pkg::NEED_W'(7);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         need_ff     <= {need_sum[ffha_pkg::NEED_W-1:2], 2'b00};
         req_zero_ff <= (request_bytes == '0);
      end
      if (cmd.latch_have) begin
         have_ff <= csize;
      end
      pos_ff <= pos_in;
   end

   // current header, with word 0 reading as the whole heap until first written
   assign hdr      = hit_ff ? HDR_W'(HEAP_BYTES) : rdata_ff;
   assign csize    = {hdr[HDR_W-1:2], 2'b00};
   assign next_pos = POS_W'(pos_ff) + POS_W'(csize);
   assign rem_pos  = SUM_W'(pos_ff) + SUM_W'(need_ff);
   assign rem_size = CMP_W'(have_ff) - CMP_W'(need_ff);

   assign status.need_bad = req_zero_ff || (CMP_W'(need_ff) > CMP_W'(HEAP_BYTES));
   assign status.hdr_zero = (csize == '0);
   assign status.hdr_fit  = (hdr[1:0] == ffha_pkg::FLAG_FREE) &&
                            (CMP_W'(need_ff) <= CMP_W'(csize));
   assign status.at_end   = (next_pos >= POS_W'(HEAP_BYTES));
   assign status.rem_ok   = (CMP_W'(have_ff) > CMP_W'(need_ff)) &&
                            (rem_pos < SUM_W'(HEAP_BYTES));

   always_comb begin
      if (cmd.clear_pos) begin
         pos_in = '0;
      end else if (cmd.advance) begin
         pos_in = next_pos[HDR_W-1:0];
      end else begin
         pos_in = pos_ff;
      end
   end

   // read the header at the next pointer so it is ready with the pointer
   assign rd_word = pos_in[ADDR_W+1:2];

   always_comb begin
      wr_en   = cmd.write_hdr || cmd.write_rem;
      wr_word = pos_ff[ADDR_W+1:2];
      wr_data = HDR_W'(need_ff) | HDR_W'(ffha_pkg::FLAG_USED);
      if (cmd.write_rem) begin
         wr_word = rem_pos[ADDR_W+1:2];
         wr_data = HDR_W'(rem_size);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_word] <= wr_data;
      end
      rdata_ff <= mem[rd_word];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b1;
         hit_ff  <= 1'b0;
      end else begin
         if (wr_en && (wr_word == '0)) begin
            init_ff <= 1'b0;
         end
         hit_ff <= init_ff && (rd_word == '0);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         grant_ok      <= cmd.grant;
         header_offset <= cmd.grant ? ffha_pkg::OFS_W'(pos_ff) : '0;
         chunk_bytes   <= cmd.grant ? ffha_pkg::BYTES_W'(need_ff) : '0;
      end
   end

endmodule

>>> rtl/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit boundary-tag allocator over an on-chip header memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one allocation request item (request_bytes). It is taken
//   only while the core is idle; one request is processed at a time.
//   rsp_ch returns one item per request: grant_ok, header_offset (header
//   offset) and chunk_bytes (size with header). Failures return all zeros.
// Sequence:
//   A zero or oversized request fails at the check. Otherwise the walk
//   visits one header per cycle (one memory read a cycle) until a free
//   chunk fits, or fails at a zero header or the heap end. A grant writes
//   the used header and, on a split, the free remainder header. The next
//   request is taken the cycle after the response loads, so the walk sets
//   the rate: at the default heap up to 8192 headers of 8 bytes.
// Reset:
//   The heap is one free chunk of HEAP_BYTES; word 0 reads as that size
//   until first written; no clearing pass runs, so the core is ready the
//   cycle after reset. HEAP_BYTES must be a multiple of 4; this is unchecked.
// Stalls:
//   The response sits in an output register; the walk for the next request
//   may run while it waits, and the core holds its finished result until
//   the register frees.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core #(
   parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ffha_req_if.sink    req_ch,
   ffha_rsp_if.source  rsp_ch
);

   ffha_pkg::cmd_type    cmd;
   ffha_pkg::status_type status;

   // sequence the walk
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold headers, pointer and the response payload
   ffha_datapath #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .request_bytes (req_ch.request_bytes),
      .grant_ok      (rsp_ch.grant_ok),
      .header_offset (rsp_ch.header_offset),
      .chunk_bytes   (rsp_ch.chunk_bytes)
   );

endmodule

>>> rtl/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator's response channel.
// ----------------------------------------------------------------------------
module ffha_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           grant_ok,
   input logic [ffha_pkg::OFS_W-1:0]     header_offset,
   input logic [ffha_pkg::BYTES_W-1:0]   chunk_bytes
);

   // nothing leaves the core right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a failed item carries no offset and no size
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !grant_ok |-> header_offset == '0 && chunk_bytes == '0)
      else $error("failed response with nonzero payload");

   // a granted chunk is word aligned and holds at least header plus one word
   a_grant_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && grant_ok |->
         header_offset[1:0] == 2'b00 && chunk_bytes[1:0] == 2'b00 &&
         chunk_bytes >= ffha_pkg::BYTES_W'(8))
      else $error("granted chunk misaligned or too small");

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(grant_ok) && $stable(header_offset) &&
         $stable(chunk_bytes))
      else $error("stalled response changed");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .grant_ok      (rsp_ch.grant_ok),
   .header_offset (rsp_ch.header_offset),
   .chunk_bytes   (rsp_ch.chunk_bytes)
);
